/* hdl/trade_tick_ring_buffer_defines.svh */
// Assertion macros used by the trade tick ring datapath.
`ifndef TRADE_TICK_RING_BUFFER_DEFINES_SVH
`define TRADE_TICK_RING_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trade tick ring: check failed");
// next-cycle implication
`define TTRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trade tick ring: check failed");
`else
`define TTRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define TTRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/ttrb_pkg.sv */
// Shared types and constants of the trade tick ring.
package ttrb_pkg;

  localparam int RING_DEPTH_DEFAULT = 64;

  localparam int PRICE_W  = 64;
  localparam int SIZE_W   = 64;
  localparam int STAMP_W  = 56;
  localparam int AGE_W    = 16;
  localparam int WIN_W    = 24;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MERGE_ENABLE = 2'd0,
    CFG_SAME_WINDOW  = 2'd1,
    CFG_ANY_WINDOW   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_STAMP = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_COMMIT = 2'd2
  } ctrl_state_t;

  // one ring entry as stored in memory
  typedef struct packed {
    logic               buy;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic evaluate;
    logic commit;
    logic write_entry;
    logic merge;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic stamp_zero;
    logic merge_hit;
  } stat_t;

endpackage

/* hdl/trade_tick_ring_buffer.sv */
// Top level of the trade tick ring: controller plus datapath.
//
// Usage:
//   Commands enter on start while busy is low; op selects append (trade in
//   buy/price/size/stamp_us) or read (entry picked by age, 0 = newest).
//   Each transaction yields exactly one result: done is high for one cycle
//   with status, merged and the out_* fields valid in that cycle.
//   Config registers (merge enable, two merge windows) are written through
//   cfg_we/cfg_index/cfg_wdata while no command is in flight.
// Timing:
//   After the accepting edge the controller steps through its lookup and
//   commit states with busy high, and done is registered from the commit
//   state. A new command may be accepted in the cycle where done is high,
//   so commands do not overlap. The steps are the entry RAM's registered
//   read, the window compare and saturating add, and the write back of the newest slot.
// Reset:
//   rst clears state, config and ring pointers at once; slots are tracked by
//   a fill count, so no clearing pass is needed. Results cannot be stalled.
module trade_tick_ring_buffer #(
  parameter int RING_DEPTH = ttrb_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic                                buy,
  input  logic signed [ttrb_pkg::PRICE_W-1:0] price,
  input  logic signed [ttrb_pkg::SIZE_W-1:0]  size,
  input  logic [ttrb_pkg::STAMP_W-1:0]        stamp_us,
  input  logic [ttrb_pkg::AGE_W-1:0]          age,
  input  logic                                cfg_we,
  input  logic [ttrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttrb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                done,
  output logic [ttrb_pkg::STATUS_W-1:0]       status,
  output logic                                merged,
  output logic                                out_buy,
  output logic signed [ttrb_pkg::PRICE_W-1:0] out_price,
  output logic signed [ttrb_pkg::SIZE_W-1:0]  out_size,
  output logic [ttrb_pkg::STAMP_W-1:0]        out_stamp_us
);
  import ttrb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ttrb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ttrb_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .op           (op),
    .buy          (buy),
    .price        (price),
    .size         (size),
    .stamp_us     (stamp_us),
    .age          (age),
    .done         (done),
    .status       (status),
    .merged       (merged),
    .out_buy      (out_buy),
    .out_price    (out_price),
    .out_size     (out_size),
    .out_stamp_us (out_stamp_us)
  );

endmodule

/* hdl/ttrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ttrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ttrb_ctrl.sv */
// Controller state machine: sequences lookup, evaluate and commit per transaction.
module ttrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ttrb_pkg::stat_t stat,
  output ttrb_pkg::cmd_t  cmd,
  output logic            busy
);
  import ttrb_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.evaluate = 1'b1;
        state_next   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        // appends with a valid stamp touch the ring
        if (!stat.is_read && !stat.stamp_zero) begin
          cmd.write_entry = 1'b1;
          cmd.merge       = stat.merge_hit;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ttrb_datapath.sv */
// Datapath: config registers, ring pointers, entry RAM, merge logic and result registers.
`include "trade_tick_ring_buffer_defines.svh"
module ttrb_datapath #(
  parameter int RING_DEPTH = ttrb_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ttrb_pkg::cmd_t                      cmd,
  output ttrb_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [ttrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttrb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                op,
  input  logic                                buy,
  input  logic signed [ttrb_pkg::PRICE_W-1:0] price,
  input  logic signed [ttrb_pkg::SIZE_W-1:0]  size,
  input  logic [ttrb_pkg::STAMP_W-1:0]        stamp_us,
  input  logic [ttrb_pkg::AGE_W-1:0]          age,
  output logic                                done,
  output logic [ttrb_pkg::STATUS_W-1:0]       status,
  output logic                                merged,
  output logic                                out_buy,
  output logic signed [ttrb_pkg::PRICE_W-1:0] out_price,
  output logic signed [ttrb_pkg::SIZE_W-1:0]  out_size,
  output logic [ttrb_pkg::STAMP_W-1:0]        out_stamp_us
);
  import ttrb_pkg::*;

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int ENTRY_W = $bits(entry_t);

  // saturating two's complement add
  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W-1:0] s;
    s = a + b;
    if (a[SIZE_W-1] == b[SIZE_W-1] && s[SIZE_W-1] != a[SIZE_W-1]) begin
      s = a[SIZE_W-1] ? {1'b1, {(SIZE_W-1){1'b0}}} : {1'b0, {(SIZE_W-1){1'b1}}};
    end
    return s;
  endfunction

  // configuration registers
  logic             merge_enable;
  logic [WIN_W-1:0] same_win;
  logic [WIN_W-1:0] any_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_enable <= 1'b0;
      same_win     <= '0;
      any_win      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MERGE_ENABLE: merge_enable <= cfg_wdata[0];
        CFG_SAME_WINDOW:  same_win     <= cfg_wdata[WIN_W-1:0];
        CFG_ANY_WINDOW:   any_win      <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ring pointers; slots fill in order, so a slot is occupied iff below fill_count
  logic [IDX_W-1:0]  newest_slot;
  logic [FILL_W-1:0] fill_count;
  logic              has_data;
  logic [IDX_W-1:0]  next_slot;

  assign has_data  = (fill_count != '0);
  assign next_slot = !has_data ? '0 :
                     (newest_slot == IDX_W'(RING_DEPTH - 1)) ? '0 :
                     newest_slot + IDX_W'(1);

  // read slot counted back from the newest entry
  logic               age_ok;
  logic [IDX_W-1:0]   age_idx;
  logic [IDX_W:0]     back_wide;
  logic [IDX_W-1:0]   read_slot;

  assign age_ok    = ({1'b0, age} < (AGE_W + 1)'(RING_DEPTH));
  assign age_idx   = age[IDX_W-1:0];
  assign back_wide = (age_idx <= newest_slot) ?
                     ({1'b0, newest_slot} - {1'b0, age_idx}) :
                     ({1'b0, newest_slot} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, age_idx});
  assign read_slot = back_wide[IDX_W-1:0];

  // captured transaction
  logic               req_op;
  logic               req_buy;
  logic [PRICE_W-1:0] req_price;
  logic [SIZE_W-1:0]  req_size;
  logic [STAMP_W-1:0] req_stamp;
  logic [IDX_W-1:0]   req_slot;
  logic               req_age_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= op;
      req_buy    <= buy;
      req_price  <= price;
      req_size   <= size;
      req_stamp  <= stamp_us;
      req_slot   <= read_slot;
      req_age_ok <= age_ok;
    end
  end

  // entry memory
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           wr_entry;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;

  assign ram_raddr = (op == OP_READ) ? read_slot : newest_slot;
  assign rd_entry  = entry_t'(ram_rdata);

  ttrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (cmd.capture),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // evaluate: window checks and accumulated size
  logic              win_same_hit;
  logic              win_any_hit;
  logic              merge_hit;
  logic [SIZE_W-1:0] acc_size;
  logic              slot_valid;

  assign win_same_hit = (({1'b0, rd_entry.stamp} + (STAMP_W + 1)'(same_win)) >
                         {1'b0, req_stamp});
  assign win_any_hit  = (({1'b0, rd_entry.stamp} + (STAMP_W + 1)'(any_win)) >
                         {1'b0, req_stamp});

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      merge_hit  <= merge_enable && has_data && (rd_entry.buy == req_buy) &&
                    ((win_same_hit && (rd_entry.price == req_price)) || win_any_hit);
      acc_size   <= sat_add(rd_entry.size, req_size);
      slot_valid <= req_age_ok && (FILL_W'(req_slot) < fill_count);
    end
  end

  assign stat.is_read    = (req_op == OP_READ);
  assign stat.stamp_zero = (req_stamp == '0);
  assign stat.merge_hit  = merge_hit;

  // commit: write port; both merge kinds store the new price (equal in the same-price case)
  assign ram_we         = cmd.write_entry;
  assign ram_waddr      = cmd.merge ? newest_slot : next_slot;
  assign wr_entry.buy   = req_buy;
  assign wr_entry.price = req_price;
  assign wr_entry.size  = cmd.merge ? acc_size : req_size;
  assign wr_entry.stamp = req_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot <= '0;
      fill_count  <= '0;
    end else if (cmd.write_entry && !cmd.merge) begin
      newest_slot <= next_slot;
      if (fill_count != FILL_W'(RING_DEPTH)) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      merged       <= 1'b0;
      out_buy      <= 1'b0;
      out_price    <= '0;
      out_size     <= '0;
      out_stamp_us <= '0;
      if (req_op == OP_READ) begin
        if (slot_valid) begin
          status       <= STATUS_OK;
          out_buy      <= rd_entry.buy;
          out_price    <= rd_entry.price;
          out_size     <= rd_entry.size;
          out_stamp_us <= rd_entry.stamp;
        end else begin
          status <= STATUS_RANGE;
        end
      end else if (req_stamp == '0) begin
        status <= STATUS_BAD_STAMP;
      end else begin
        status <= STATUS_OK;
        merged <= cmd.merge;
      end
    end
  end

  // checks
  `TTRB_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill_count <= FILL_W'(RING_DEPTH))
  `TTRB_ASSERT_NOW(a_newest_occupied, clk, rst, has_data, FILL_W'(newest_slot) < fill_count)
  `TTRB_ASSERT_NEXT(a_merge_keeps_ptr, clk, rst, cmd.commit && cmd.merge, $stable(newest_slot) && $stable(fill_count))
  `TTRB_ASSERT_NOW(a_read_no_write, clk, rst, cmd.commit && (req_op == OP_READ), !ram_we)

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the trade tick ring: directed and random transactions.
`timescale 1ns / 1ps

module testbench;
  import ttrb_pkg::*;

  localparam int DEPTH        = RING_DEPTH_DEFAULT;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORT_MAX   = 10;
  localparam int PHASE_ITEMS  = 190;

  // index past the three registers; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [PRICE_W-1:0] FIX_MAX   = {1'b0, {(PRICE_W-1){1'b1}}};
  localparam logic [PRICE_W-1:0] FIX_MIN   = {1'b1, {(PRICE_W-1){1'b0}}};
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [WIN_W-1:0]   WIN_MAX   = '1;

  typedef struct {
    op_t                op;
    logic               buy;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
    logic [AGE_W-1:0]   age;
  } trade_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                merged;
    logic                buy;
    logic [PRICE_W-1:0]  price;
    logic [SIZE_W-1:0]   size;
    logic [STAMP_W-1:0]  stamp;
  } trade_result_t;

  // Mirror of the ring contents and registers; predicts and checks each result.
  class tick_ring_scoreboard;
    logic [PRICE_W-1:0] slot_price[DEPTH];
    logic [SIZE_W-1:0]  slot_size[DEPTH];
    logic               slot_buy[DEPTH];
    logic [STAMP_W-1:0] slot_stamp[DEPTH];
    int unsigned        newest;
    bit                 filled;
    bit                 merge_on;
    logic [WIN_W-1:0]   same_win;
    logic [WIN_W-1:0]   any_win;
    trade_result_t      pending_results[$];
    int unsigned        mismatches;

    function new();
      foreach (slot_stamp[i]) begin
        slot_price[i] = '0;
        slot_size[i]  = '0;
        slot_buy[i]   = 1'b0;
        slot_stamp[i] = '0;
      end
      newest     = 0;
      filled     = 1'b0;
      merge_on   = 1'b0;
      same_win   = '0;
      any_win    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MERGE_ENABLE: merge_on = data[0];
        CFG_SAME_WINDOW:  same_win = data[WIN_W-1:0];
        CFG_ANY_WINDOW:   any_win  = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // two's complement add clamped to the signed 64-bit range
    function logic [SIZE_W-1:0] add_clamped(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
      logic [SIZE_W-1:0] sum;
      sum = a + b;
      if (a[SIZE_W-1] == b[SIZE_W-1] && sum[SIZE_W-1] != a[SIZE_W-1])
        return a[SIZE_W-1] ? FIX_MIN : FIX_MAX;
      return sum;
    endfunction

    // old + window > stamp, evaluated wide enough not to wrap
    function bit in_window(logic [STAMP_W-1:0] old, logic [WIN_W-1:0] win,
                           logic [STAMP_W-1:0] stamp);
      return ({8'd0, old} + {40'd0, win}) > {8'd0, stamp};
    endfunction

    function void store(int unsigned slot, trade_cmd_t c);
      slot_price[slot] = c.price;
      slot_size[slot]  = c.size;
      slot_buy[slot]   = c.buy;
      slot_stamp[slot] = c.stamp;
    endfunction

    // called once per accepted transaction
    function void log_command(trade_cmd_t c);
      trade_result_t r;
      int unsigned   slot;
      bit            same_side;
      r.status = STATUS_OK;
      r.merged = 1'b0;
      r.buy    = 1'b0;
      r.price  = '0;
      r.size   = '0;
      r.stamp  = '0;
      if (c.op == OP_APPEND) begin
        same_side = filled && (slot_buy[newest] == c.buy);
        if (c.stamp == '0) begin
          r.status = STATUS_BAD_STAMP;
        end else if (!filled) begin
          newest = 0;
          filled = 1'b1;
          store(0, c);
        end else if (merge_on && same_side && slot_price[newest] == c.price &&
                     in_window(slot_stamp[newest], same_win, c.stamp)) begin
          slot_size[newest]  = add_clamped(slot_size[newest], c.size);
          slot_stamp[newest] = c.stamp;
          r.merged = 1'b1;
        end else if (merge_on && same_side &&
                     in_window(slot_stamp[newest], any_win, c.stamp)) begin
          slot_size[newest]  = add_clamped(slot_size[newest], c.size);
          slot_price[newest] = c.price;
          slot_stamp[newest] = c.stamp;
          r.merged = 1'b1;
        end else begin
          newest = (newest + 1) % DEPTH;
          store(newest, c);
        end
      end else begin
        slot = (newest + DEPTH - c.age) % DEPTH;
        if (c.age >= DEPTH || slot_stamp[slot] == '0) begin
          r.status = STATUS_RANGE;
        end else begin
          r.buy   = slot_buy[slot];
          r.price = slot_price[slot];
          r.size  = slot_size[slot];
          r.stamp = slot_stamp[slot];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(trade_result_t got);
      trade_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result with none outstanding, status %0d", got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.merged !== want.merged ||
          got.buy !== want.buy || got.price !== want.price ||
          got.size !== want.size || got.stamp !== want.stamp) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $write("ERROR: mismatch (exp/act) status %0d/%0d merged %b/%b buy %b/%b",
                 want.status, got.status, want.merged, got.merged, want.buy, got.buy);
          $display(" price %h/%h size %h/%h stamp %h/%h",
                   want.price, got.price, want.size, got.size, want.stamp, got.stamp);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     op;
  logic                     buy;
  logic signed [PRICE_W-1:0] price;
  logic signed [SIZE_W-1:0] size;
  logic [STAMP_W-1:0]       stamp_us;
  logic [AGE_W-1:0]         age;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic                     merged;
  logic                     out_buy;
  logic signed [PRICE_W-1:0] out_price;
  logic signed [SIZE_W-1:0] out_size;
  logic [STAMP_W-1:0]       out_stamp_us;

  tick_ring_scoreboard board = new();

  // random stream state
  logic [STAMP_W-1:0] now_us;
  logic [PRICE_W-1:0] last_price;
  logic               last_buy;
  int unsigned        step_span;
  bit                 steady;
  int unsigned        cycle_count;
  trade_cmd_t         script[$];

  trade_tick_ring_buffer i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .buy(buy),
    .price(price), .size(size), .stamp_us(stamp_us), .age(age),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .merged(merged), .out_buy(out_buy),
    .out_price(out_price), .out_size(out_size), .out_stamp_us(out_stamp_us)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // each result is flagged by done, which is high for one cycle only
  always @(posedge clk) begin
    if (!rst && done)
      board.check_result('{status, merged, out_buy, out_price, out_size, out_stamp_us});
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic trade_cmd_t trade(logic b, logic [PRICE_W-1:0] p,
                                       logic [SIZE_W-1:0] s, logic [STAMP_W-1:0] t);
    trade_cmd_t c;
    c.op    = OP_APPEND;
    c.buy   = b;
    c.price = p;
    c.size  = s;
    c.stamp = t;
    c.age   = '0;
    return c;
  endfunction

  function automatic trade_cmd_t lookup(logic [AGE_W-1:0] a);
    trade_cmd_t c;
    c.op    = OP_READ;
    c.buy   = 1'b0;
    c.price = '0;
    c.size  = '0;
    c.stamp = '0;
    c.age   = a;
    return c;
  endfunction

  // mostly follows a running clock so that the merge windows get hit
  function automatic trade_cmd_t random_trade();
    trade_cmd_t  c;
    int unsigned pick;
    c.op  = OP_APPEND;
    c.age = AGE_W'($urandom);
    c.buy = ($urandom_range(0, 99) < 75) ? last_buy : 1'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 50)      c.price = last_price;
    else if (pick < 65) c.price = last_price + 64'($urandom_range(0, 4)) - 64'd2;
    else if (pick < 85) c.price = {$urandom, $urandom};
    else if (pick < 90) c.price = FIX_MAX;
    else if (pick < 95) c.price = FIX_MIN;
    else                c.price = '0;

    pick = $urandom_range(0, 99);
    if (pick < 60)      c.size = 64'($urandom_range(0, 2000000)) - 64'd1000000;
    else if (pick < 80) c.size = {$urandom, $urandom};
    else if (pick < 90) c.size = FIX_MAX - 64'($urandom_range(0, 3));
    else                c.size = FIX_MIN + 64'($urandom_range(0, 3));

    pick = $urandom_range(0, 99);
    if (pick < 70)      c.stamp = now_us + STAMP_W'($urandom_range(0, step_span));
    else if (pick < 80) c.stamp = now_us - STAMP_W'($urandom_range(0, step_span));
    else if (pick < 92) c.stamp = STAMP_W'({$urandom, $urandom});
    else if (pick < 96) c.stamp = '0;
    else                c.stamp = STAMP_MAX;

    if (c.stamp != '0) now_us = c.stamp;
    last_price = c.price;
    last_buy   = c.buy;
    return c;
  endfunction

  function automatic trade_cmd_t random_lookup();
    trade_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      c = lookup(AGE_W'($urandom_range(0, 3)));
    else if (pick < 88) c = lookup(AGE_W'($urandom_range(0, DEPTH - 1)));
    else                c = lookup(AGE_W'($urandom_range(DEPTH, 65535)));
    // trade fields are ignored on a read; keep them moving anyway
    c.buy   = 1'($urandom);
    c.price = {$urandom, $urandom};
    c.size  = {$urandom, $urandom};
    c.stamp = STAMP_W'({$urandom, $urandom});
    return c;
  endfunction

  // hold start until the transaction is taken
  task automatic send_cmd(trade_cmd_t c);
    start    <= 1'b1;
    op       <= c.op;
    buy      <= c.buy;
    price    <= c.price;
    size     <= c.size;
    stamp_us <= c.stamp;
    age      <= c.age;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.log_command(c);
  endtask

  task automatic pause_maybe();
    int unsigned gap;
    int unsigned pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!steady && pick >= 55)
      gap = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic play_script();
    foreach (script[i]) begin
      send_cmd(script[i]);
      pause_maybe();
    end
    script.delete();
  endtask

  // block is idle once every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic program_regs(bit merge, logic [WIN_W-1:0] same_w,
                              logic [WIN_W-1:0] any_w, bit poke_unused);
    cfg_write(CFG_MERGE_ENABLE, {23'($urandom), merge});
    cfg_write(CFG_SAME_WINDOW, same_w);
    cfg_write(CFG_ANY_WINDOW, any_w);
    if (poke_unused) cfg_write(CFG_UNUSED, '1);
    cfg_we    <= 1'b0;
    step_span = 2 * ((same_w > any_w) ? same_w : any_w) + 16;
  endtask

  initial begin
    int unsigned        ph;
    logic [WIN_W-1:0]   win_a;
    logic [WIN_W-1:0]   win_b;
    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_APPEND;
    buy        <= 1'b0;
    price      <= '0;
    size       <= '0;
    stamp_us   <= '0;
    age        <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_MERGE_ENABLE;
    cfg_wdata  <= '0;
    now_us     = STAMP_W'(1000);
    last_price = '0;
    last_buy   = 1'b0;
    step_span  = 16;
    steady     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: empty ring, bad stamp, field extremes
    script.push_back(lookup(0));
    script.push_back(lookup(AGE_W'(DEPTH - 1)));
    script.push_back(lookup(AGE_W'(DEPTH)));
    script.push_back(lookup('1));
    script.push_back(trade(1'b1, FIX_MAX, FIX_MAX, '0));
    script.push_back(trade(1'b1, FIX_MAX, FIX_MAX, STAMP_MAX));
    script.push_back(lookup(0));
    script.push_back(trade(1'b0, FIX_MIN, FIX_MIN, 1));
    script.push_back(lookup(1));
    script.push_back(lookup(0));
    script.push_back(lookup(2));
    play_script();

    // both merge kinds, window edges, backwards time, clamping both ways
    drain();
    program_regs(1'b1, 1000, 5000, 1'b1);
    script.push_back(trade(1'b1, 5, 100, 10000));
    script.push_back(trade(1'b1, 5, FIX_MAX, 10999));
    script.push_back(trade(1'b1, 5, 1, 11999));
    script.push_back(trade(1'b1, 9, -3, 100));
    script.push_back(trade(1'b1, 9, 1, 5100));
    script.push_back(trade(1'b0, 9, FIX_MIN, 5200));
    script.push_back(trade(1'b0, 9, -1, 5300));
    script.push_back(lookup(0));
    script.push_back(lookup(1));
    script.push_back(lookup(2));
    script.push_back(lookup(3));
    play_script();

    // widest windows: stamp at its top, then a wrapped-looking earlier stamp
    drain();
    program_regs(1'b1, WIN_MAX, WIN_MAX, 1'b0);
    script.push_back(trade(1'b0, 1, 1, STAMP_MAX));
    script.push_back(trade(1'b0, 1, 2, 1));
    script.push_back(lookup(0));
    script.push_back(lookup(1));
    play_script();

    // random phases, each under its own register setting
    for (ph = 0; ph < 5; ph++) begin
      win_a = WIN_W'($urandom_range(1, 2000));
      win_b = WIN_W'($urandom);
      drain();
      case (ph)
        0: program_regs(1'b1, win_a, WIN_W'(win_a * 4), 1'b0);
        1: program_regs(1'b1, WIN_MAX, WIN_MAX, 1'b0);
        2: program_regs(1'b0, win_b, WIN_MAX, 1'b0);
        3: program_regs(1'b1, '0, win_a, 1'b1);
        default: program_regs(1'b1, win_b, WIN_W'($urandom), 1'b0);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 60) send_cmd(random_trade());
        else                            send_cmd(random_lookup());
        pause_maybe();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
